@@ rtl/swbc_pkg.sv @@
// types, widths and helper functions for the swept box collision core
package swbc_pkg;

  localparam int CW   = 32;
  localparam int HW   = 31;
  localparam int VW   = 33;
  localparam int LW   = 34;
  localparam int FRAC = 16;
  localparam int DW   = 32;
  localparam int QW   = LW - 1 + FRAC;
  localparam int RW   = QW + 1;
  localparam int NF   = 4;

  localparam logic signed [RW-1:0] T_ONE  = RW'(1) << FRAC;
  localparam logic signed [RW-1:0] T_ZERO = '0;

  localparam logic [1:0] NRM_NEG  = 2'b11;
  localparam logic [1:0] NRM_ZERO = 2'b00;
  localparam logic [1:0] NRM_POS  = 2'b01;

  typedef struct packed {
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [LW-1:0] mnx;
    logic signed [LW-1:0] mxx;
    logic signed [LW-1:0] mny;
    logic signed [LW-1:0] mxy;
    logic signed [LW-1:0] hxn;
    logic signed [LW-1:0] hxp;
    logic signed [LW-1:0] hyn;
    logic signed [LW-1:0] hyp;
    logic                 inter;
  } geom_t;

  typedef struct packed {
    logic                 empty;
    logic                 t1v;
    logic                 t2v;
    logic signed [RW-1:0] t1;
    logic signed [RW-1:0] t2;
    logic [1:0]           n1x;
    logic [1:0]           n1y;
    logic [1:0]           n2x;
    logic [1:0]           n2y;
  } clip_t;

  typedef struct packed {
    logic       pz;
    logic       pn;
    logic       qle0;
    logic [1:0] nx;
    logic [1:0] ny;
  } face_t;

  typedef struct packed {
    logic signed [CW-1:0] t;
    logic [1:0]           nx;
    logic [1:0]           ny;
    logic                 ov;
    logic signed [LW-1:0] base_x;
    logic signed [LW-1:0] base_y;
    logic                 mul_x;
    logic                 mul_y;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
  } dec_t;

  function automatic logic [LW-1:0] mag_l(logic signed [LW-1:0] v);
    return v[LW-1] ? LW'(-v) : LW'(v);
  endfunction

  function automatic logic [VW-1:0] mag_v(logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic signed [RW-1:0] apply_sign(logic [QW-1:0] q, logic neg);
    logic signed [RW-1:0] r;
    r = $signed({1'b0, q});
    return neg ? -r : r;
  endfunction

  function automatic logic signed [CW-1:0] sat_cw(logic signed [RW-1:0] v);
    if ((&v[RW-1:CW-1]) || !(|v[RW-1:CW-1])) begin
      return v[CW-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  function automatic face_t face_in(geom_t g, int f);
    face_t o;
    o = '0;
    if (f == 0) begin
      o.pz = (g.vx == '0); o.pn = !g.vx[VW-1] && (g.vx != '0);
      o.qle0 = !g.mnx[LW-1]; o.nx = NRM_NEG;
    end else if (f == 1) begin
      o.pz = (g.vx == '0); o.pn = g.vx[VW-1];
      o.qle0 = g.mxx[LW-1] || (g.mxx == '0); o.nx = NRM_POS;
    end else if (f == 2) begin
      o.pz = (g.vy == '0); o.pn = !g.vy[VW-1] && (g.vy != '0);
      o.qle0 = !g.mny[LW-1]; o.ny = NRM_NEG;
    end else begin
      o.pz = (g.vy == '0); o.pn = g.vy[VW-1];
      o.qle0 = g.mxy[LW-1] || (g.mxy == '0); o.ny = NRM_POS;
    end
    return o;
  endfunction

  function automatic clip_t clip_face(clip_t c, face_t f, logic signed [RW-1:0] r);
    clip_t o;
    o = c;
    if (!c.empty) begin
      if (f.pz) begin
        if (f.qle0) o.empty = 1'b1;
      end else if (f.pn) begin
        if (c.t2v && r > c.t2) begin
          o.empty = 1'b1;
        end else if (!c.t1v || r > c.t1) begin
          o.t1 = r; o.t1v = 1'b1; o.n1x = f.nx; o.n1y = f.ny;
        end
      end else begin
        if (c.t1v && r < c.t1) begin
          o.empty = 1'b1;
        end else if (!c.t2v || r < c.t2) begin
          o.t2 = r; o.t2v = 1'b1; o.n2x = f.nx; o.n2y = f.ny;
        end
      end
    end
    return o;
  endfunction

endpackage

@@ rtl/swbc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module swbc_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [swbc_pkg::QW-1:0]    num_i,
  input  logic [swbc_pkg::DW-1:0]    den_i,
  output logic [swbc_pkg::QW-1:0]    quot_o
);

  localparam int QW = swbc_pkg::QW;
  localparam int DW = swbc_pkg::DW;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] nq_q  [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rs;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rs   = {rem_in, nq_in[QW-1]};
    assign ge   = (rs >= {1'b0, den_in});
    assign diff = rs - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : rs[DW-1:0];
        nq_q[k]  <= {nq_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = nq_q[QW-1];

endmodule

@@ rtl/swept_box_collision_core.sv @@
// swept box collision core: top level pipeline
// Streams one collision query per cycle: a moving box against a static box, clipped
// Liang-Barsky style in signed Q16.16. The pipeline depth is set by the four
// pipelined face dividers, which produce one quotient bit per stage. Back-pressure
// on the result freezes the whole pipeline, so throughput stays one item per cycle
// while the result is taken.
module swept_box_collision_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             body_center_x_i,
  input  logic signed [31:0]             body_center_y_i,
  input  logic [30:0]                    body_half_x_i,
  input  logic [30:0]                    body_half_y_i,
  input  logic signed [31:0]             target_x_i,
  input  logic signed [31:0]             target_y_i,
  input  logic signed [31:0]             obstacle_center_x_i,
  input  logic signed [31:0]             obstacle_center_y_i,
  input  logic [30:0]                    obstacle_half_x_i,
  input  logic [30:0]                    obstacle_half_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             hit_time_o,
  output logic signed [31:0]             resolved_x_o,
  output logic signed [31:0]             resolved_y_o,
  output logic signed [1:0]              normal_x_o,
  output logic signed [1:0]              normal_y_o,
  output logic                           overlapping_o
);

  localparam int QW   = swbc_pkg::QW;
  localparam int DW   = swbc_pkg::DW;
  localparam int LW   = swbc_pkg::LW;
  localparam int VW   = swbc_pkg::VW;
  localparam int RW   = swbc_pkg::RW;
  localparam int CW   = swbc_pkg::CW;
  localparam int FRAC = swbc_pkg::FRAC;
  localparam int NF   = swbc_pkg::NF;
  localparam int PW   = VW + CW;
  localparam int NST  = QW + 9;
  localparam int S_R  = QW + 1;
  localparam int S_D  = QW + 6;

  logic adv;
  logic [NST-1:0] vld_q;

  assign adv        = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // setup stage
  swbc_pkg::geom_t geom_d, geom_a_q;
  logic signed [LW-1:0] bx_l, by_l, ox_l, oy_l;

  always_comb begin
    bx_l = LW'(body_center_x_i);
    by_l = LW'(body_center_y_i);
    ox_l = LW'(obstacle_center_x_i);
    oy_l = LW'(obstacle_center_y_i);
    geom_d.bx  = body_center_x_i;
    geom_d.by  = body_center_y_i;
    geom_d.tx  = target_x_i;
    geom_d.ty  = target_y_i;
    geom_d.vx  = VW'(target_x_i) - VW'(body_center_x_i);
    geom_d.vy  = VW'(target_y_i) - VW'(body_center_y_i);
    geom_d.mnx = ox_l - LW'(obstacle_half_x_i) - bx_l - LW'(body_half_x_i);
    geom_d.mxx = ox_l + LW'(obstacle_half_x_i) - bx_l + LW'(body_half_x_i);
    geom_d.mny = oy_l - LW'(obstacle_half_y_i) - by_l - LW'(body_half_y_i);
    geom_d.mxy = oy_l + LW'(obstacle_half_y_i) - by_l + LW'(body_half_y_i);
    geom_d.hxn = ox_l - LW'(obstacle_half_x_i) - LW'(body_half_x_i);
    geom_d.hxp = ox_l + LW'(obstacle_half_x_i) + LW'(body_half_x_i);
    geom_d.hyn = oy_l - LW'(obstacle_half_y_i) - LW'(body_half_y_i);
    geom_d.hyp = oy_l + LW'(obstacle_half_y_i) + LW'(body_half_y_i);
    geom_d.inter = geom_d.mnx[LW-1] && !geom_d.mxx[LW-1] && (geom_d.mxx != '0) &&
                   geom_d.mny[LW-1] && !geom_d.mxy[LW-1] && (geom_d.mxy != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) geom_a_q <= geom_d;
  end

  // face dividers
  logic [LW-1:0] mag_f [NF];
  logic [VW-1:0] mag_vx, mag_vy;
  logic [QW-1:0] num_f [NF];
  logic [QW-1:0] quot_f [NF];

  always_comb begin
    mag_f[0] = swbc_pkg::mag_l(geom_a_q.mnx);
    mag_f[1] = swbc_pkg::mag_l(geom_a_q.mxx);
    mag_f[2] = swbc_pkg::mag_l(geom_a_q.mny);
    mag_f[3] = swbc_pkg::mag_l(geom_a_q.mxy);
    mag_vx   = swbc_pkg::mag_v(geom_a_q.vx);
    mag_vy   = swbc_pkg::mag_v(geom_a_q.vy);
    for (int f = 0; f < NF; f++) begin
      num_f[f] = {mag_f[f][QW-FRAC-1:0], {FRAC{1'b0}}};
    end
  end

  for (genvar f = 0; f < NF; f++) begin : g_div
    swbc_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num_f[f]),
      .den_i  ((f < 2) ? mag_vx[DW-1:0] : mag_vy[DW-1:0]),
      .quot_o (quot_f[f])
    );
  end

  swbc_pkg::geom_t gd_q [QW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gd_q[0] <= geom_a_q;
      for (int k = 1; k < QW; k++) gd_q[k] <= gd_q[k-1];
    end
  end

  // signed ratios
  swbc_pkg::geom_t geom_r_q;
  logic signed [RW-1:0] rat_r_q [NF];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      geom_r_q   <= gd_q[QW-1];
      rat_r_q[0] <= swbc_pkg::apply_sign(quot_f[0], gd_q[QW-1].mnx[LW-1] ^ gd_q[QW-1].vx[VW-1]);
      rat_r_q[1] <= swbc_pkg::apply_sign(quot_f[1], gd_q[QW-1].mxx[LW-1] ^ gd_q[QW-1].vx[VW-1]);
      rat_r_q[2] <= swbc_pkg::apply_sign(quot_f[2], gd_q[QW-1].mny[LW-1] ^ gd_q[QW-1].vy[VW-1]);
      rat_r_q[3] <= swbc_pkg::apply_sign(quot_f[3], gd_q[QW-1].mxy[LW-1] ^ gd_q[QW-1].vy[VW-1]);
    end
  end

  // one face per stage
  swbc_pkg::geom_t      geom_c_q [NF];
  swbc_pkg::clip_t      clip_q   [NF];
  logic signed [RW-1:0] ratc_q   [NF][NF];

  for (genvar i = 0; i < NF; i++) begin : g_clip
    swbc_pkg::geom_t      g_in;
    swbc_pkg::clip_t      c_in;
    logic signed [RW-1:0] r_in [NF];

    if (i == 0) begin : g_first
      assign g_in = geom_r_q;
      assign c_in = '0;
      assign r_in = rat_r_q;
    end else begin : g_next
      assign g_in = geom_c_q[i-1];
      assign c_in = clip_q[i-1];
      assign r_in = ratc_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        geom_c_q[i] <= g_in;
        ratc_q[i]   <= r_in;
        clip_q[i]   <= swbc_pkg::clip_face(c_in, swbc_pkg::face_in(g_in, i), r_in[i]);
      end
    end
  end

  // decision stage
  swbc_pkg::geom_t      gc;
  swbc_pkg::clip_t      cc;
  swbc_pkg::dec_t       dec_d, dec_q;
  logic                 ok, take1, hit;
  logic signed [RW-1:0] t_w;
  logic [LW-1:0]        px_m, py_m;
  logic signed [LW-1:0] px, py;

  always_comb begin
    gc    = geom_c_q[NF-1];
    cc    = clip_q[NF-1];
    dec_d = '0;
    dec_d.vx = gc.vx;
    dec_d.vy = gc.vy;
    ok    = !cc.empty && !(cc.t1v && cc.t2v && (cc.t1 > cc.t2));
    take1 = (cc.t1v && cc.t2v) ? (swbc_pkg::mag_l(LW'(0)) == '0 &&
            ((cc.t1[RW-1] ? -cc.t1 : cc.t1) <= (cc.t2[RW-1] ? -cc.t2 : cc.t2)))
            : (cc.t1v || !cc.t2v);
    hit   = 1'b0;
    t_w   = swbc_pkg::T_ONE;
    px    = (swbc_pkg::mag_l(gc.mnx) < swbc_pkg::mag_l(gc.mxx)) ? gc.mnx : gc.mxx;
    py    = (swbc_pkg::mag_l(gc.mny) < swbc_pkg::mag_l(gc.mxy)) ? gc.mny : gc.mxy;
    px_m  = swbc_pkg::mag_l(px);
    py_m  = swbc_pkg::mag_l(py);
    priority if (gc.inter && gc.vx == '0 && gc.vy == '0) begin
      dec_d.t  = '0;
      dec_d.ov = 1'b1;
      dec_d.base_x = LW'(gc.bx);
      dec_d.base_y = LW'(gc.by);
      if (px_m <= py_m) begin
        dec_d.nx = (!px[LW-1] && px != '0) ? swbc_pkg::NRM_POS : swbc_pkg::NRM_NEG;
      end else begin
        dec_d.ny = (!py[LW-1] && py != '0) ? swbc_pkg::NRM_POS : swbc_pkg::NRM_NEG;
      end
    end else begin
      if (ok && gc.inter) begin
        hit = 1'b1;
        if (take1) begin
          t_w = cc.t1v ? cc.t1 : swbc_pkg::T_ZERO;
          dec_d.nx = cc.n1x; dec_d.ny = cc.n1y;
        end else begin
          t_w = cc.t2;
          dec_d.nx = cc.n2x; dec_d.ny = cc.n2y;
        end
      end else if (ok && cc.t1v && !cc.t1[RW-1] && cc.t1 <= swbc_pkg::T_ONE) begin
        hit = 1'b1;
        t_w = cc.t1;
        dec_d.nx = cc.n1x; dec_d.ny = cc.n1y;
      end
      dec_d.t = swbc_pkg::sat_cw(t_w);
      if (hit) begin
        dec_d.ov = gc.inter;
        unique case (dec_d.nx)
          swbc_pkg::NRM_NEG: dec_d.base_x = gc.hxn;
          swbc_pkg::NRM_POS: dec_d.base_x = gc.hxp;
          default: begin dec_d.base_x = LW'(gc.bx); dec_d.mul_x = 1'b1; end
        endcase
        unique case (dec_d.ny)
          swbc_pkg::NRM_NEG: dec_d.base_y = gc.hyn;
          swbc_pkg::NRM_POS: dec_d.base_y = gc.hyp;
          default: begin dec_d.base_y = LW'(gc.by); dec_d.mul_y = 1'b1; end
        endcase
      end else begin
        dec_d.nx = swbc_pkg::NRM_ZERO;
        dec_d.ny = swbc_pkg::NRM_ZERO;
        dec_d.base_x = LW'(gc.tx);
        dec_d.base_y = LW'(gc.ty);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) dec_q <= dec_d;
  end

  // motion times contact time
  swbc_pkg::dec_t     dec_e_q;
  logic signed [PW-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;

  assign prod_x_d = dec_q.vx * dec_q.t;
  assign prod_y_d = dec_q.vy * dec_q.t;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_e_q  <= dec_q;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
  end

  // resolve and output register
  logic signed [RW-1:0] sum_x, sum_y;
  logic signed [PW-1:0] shx, shy;

  always_comb begin
    shx   = prod_x_q >>> FRAC;
    shy   = prod_y_q >>> FRAC;
    sum_x = RW'(dec_e_q.base_x) + (dec_e_q.mul_x ? RW'(shx) : RW'(0));
    sum_y = RW'(dec_e_q.base_y) + (dec_e_q.mul_y ? RW'(shy) : RW'(0));
  end

  logic signed [CW-1:0] hit_time_q, resolved_x_q, resolved_y_q;
  logic signed [1:0]    normal_x_q, normal_y_q;
  logic                 overlapping_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_time_q    <= dec_e_q.t;
      resolved_x_q  <= swbc_pkg::sat_cw(sum_x);
      resolved_y_q  <= swbc_pkg::sat_cw(sum_y);
      normal_x_q    <= dec_e_q.nx;
      normal_y_q    <= dec_e_q.ny;
      overlapping_q <= dec_e_q.ov;
    end
  end

  assign out_valid_o   = vld_q[NST-1];
  assign hit_time_o    = hit_time_q;
  assign resolved_x_o  = resolved_x_q;
  assign resolved_y_o  = resolved_y_q;
  assign normal_x_o    = normal_x_q;
  assign normal_y_o    = normal_y_q;
  assign overlapping_o = overlapping_q;

`ifndef SYNTHESIS
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o == 2'sd0 || normal_y_o == 2'sd0))
    else $error("normal on both axes");

  a_miss_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overlapping_o && normal_x_o == 2'sd0 && normal_y_o == 2'sd0)
    |-> (hit_time_o == 32'sd65536))
    else $error("miss without unit time");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overlapping_o && (normal_x_o != 2'sd0 || normal_y_o != 2'sd0))
    |-> (hit_time_o >= 32'sd0 && hit_time_o <= 32'sd65536))
    else $error("contact time outside motion");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[S_R] && in_stall_o) |=> vld_q[S_R])
    else $error("item lost in pipeline under stall");

  a_dec_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[S_D]) |=> vld_q[S_D + 1])
    else $error("decision item not advanced");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench for the swept box collision core: directed table, then random items
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic signed [31:0] bx, by;
    logic [30:0]        bhx, bhy;
    logic signed [31:0] tx, ty;
    logic signed [31:0] ox, oy;
    logic [30:0]        ohx, ohy;
  } query_t;

  typedef struct {
    logic signed [31:0] t, rx, ry;
    logic [1:0]         nx, ny;
    logic               ov;
  } answer_t;

  typedef struct {
    query_t  q;
    bit      typed;
    answer_t a;
  } row_t;

  localparam longint QONE = 65536;
  localparam int QUIET_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  query_t drv = '{default: '0};
  answer_t got;

  answer_t expected_answers[$];
  int errors = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int overlaps_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int quiet = 0;

  always #6 clk_i = ~clk_i;

  swept_box_collision_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .body_center_x_i    (drv.bx),
    .body_center_y_i    (drv.by),
    .body_half_x_i      (drv.bhx),
    .body_half_y_i      (drv.bhy),
    .target_x_i         (drv.tx),
    .target_y_i         (drv.ty),
    .obstacle_center_x_i(drv.ox),
    .obstacle_center_y_i(drv.oy),
    .obstacle_half_x_i  (drv.ohx),
    .obstacle_half_y_i  (drv.ohy),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .hit_time_o         (got.t),
    .resolved_x_o       (got.rx),
    .resolved_y_o       (got.ry),
    .normal_x_o         (got.nx),
    .normal_y_o         (got.ny),
    .overlapping_o      (got.ov)
  );

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic answer_t collide(query_t q);
    longint bx, by, bhx, bhy, tx, ty, ox, oy, ohx, ohy;
    longint vx, vy, mnx, mny, mxx, mxy, px, py, t, rx, ry, r, t1, t2;
    longint fp[4], fq[4];
    int fnx[4], fny[4];
    int nx, ny, n1x, n1y, n2x, n2y;
    bit inter, ov, hit, empty, t1v, t2v, take1;
    logic signed [95:0] prod, tw;
    answer_t a;
    bx = q.bx; by = q.by; tx = q.tx; ty = q.ty; ox = q.ox; oy = q.oy;
    bhx = longint'(q.bhx); bhy = longint'(q.bhy);
    ohx = longint'(q.ohx); ohy = longint'(q.ohy);
    vx = tx - bx; vy = ty - by;
    mnx = ox - ohx - bx - bhx; mny = oy - ohy - by - bhy;
    mxx = ox + ohx - bx + bhx; mxy = oy + ohy - by + bhy;
    inter = (mnx < 0 && mxx > 0 && mny < 0 && mxy > 0);
    t = QONE; rx = tx; ry = ty; nx = 0; ny = 0; ov = 0;
    if (inter && vx == 0 && vy == 0) begin
      px = absl(mnx) < absl(mxx) ? mnx : mxx;
      py = absl(mny) < absl(mxy) ? mny : mxy;
      if (absl(px) <= absl(py)) nx = px > 0 ? 1 : -1;
      else ny = py > 0 ? 1 : -1;
      t = 0; rx = bx; ry = by; ov = 1;
    end else begin
      hit = 0; empty = 0; t1v = 0; t2v = 0; t1 = 0; t2 = 0;
      n1x = 0; n1y = 0; n2x = 0; n2y = 0;
      fp = '{-vx, vx, -vy, vy};
      fq = '{-mnx, mxx, -mny, mxy};
      fnx = '{-1, 1, 0, 0};
      fny = '{0, 0, -1, 1};
      for (int f = 0; f < 4; f++) begin
        if (!empty) begin
          if (fp[f] == 0) begin
            if (fq[f] <= 0) empty = 1;
          end else begin
            r = (fq[f] * QONE) / fp[f];
            if (fp[f] < 0) begin
              if (t2v && r > t2) empty = 1;
              else if (!t1v || r > t1) begin
                t1 = r; t1v = 1; n1x = fnx[f]; n1y = fny[f];
              end
            end else begin
              if (t1v && r < t1) empty = 1;
              else if (!t2v || r < t2) begin
                t2 = r; t2v = 1; n2x = fnx[f]; n2y = fny[f];
              end
            end
          end
        end
      end
      if (!empty && !(t1v && t2v && t1 > t2)) begin
        if (inter) begin
          if (t1v && t2v) take1 = absl(t1) <= absl(t2);
          else take1 = t1v || !t2v;
          if (take1) begin
            t = t1v ? t1 : 0; nx = n1x; ny = n1y;
          end else begin
            t = t2; nx = n2x; ny = n2y;
          end
          hit = 1;
        end else if (t1v && t1 >= 0 && t1 <= QONE) begin
          t = t1; nx = n1x; ny = n1y; hit = 1;
        end
      end
      if (hit) begin
        t = sat32(t);
        ov = inter;
        tw = t;
        if (nx < 0) rx = ox - ohx - bhx;
        else if (nx > 0) rx = ox + ohx + bhx;
        else begin
          prod = vx; prod = prod * tw;
          rx = bx + longint'(prod >>> 16);
        end
        if (ny < 0) ry = oy - ohy - bhy;
        else if (ny > 0) ry = oy + ohy + bhy;
        else begin
          prod = vy; prod = prod * tw;
          ry = by + longint'(prod >>> 16);
        end
        rx = sat32(rx); ry = sat32(ry);
      end else begin
        t = QONE; rx = tx; ry = ty; nx = 0; ny = 0; ov = 0;
      end
    end
    a.t = t[31:0]; a.rx = rx[31:0]; a.ry = ry[31:0];
    a.nx = nx == 0 ? swbc_pkg::NRM_ZERO : (nx > 0 ? swbc_pkg::NRM_POS : swbc_pkg::NRM_NEG);
    a.ny = ny == 0 ? swbc_pkg::NRM_ZERO : (ny > 0 ? swbc_pkg::NRM_POS : swbc_pkg::NRM_NEG);
    a.ov = ov;
    return a;
  endfunction

  task automatic report(string what, longint g, longint e);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, g, e);
  endtask

  // result side: stall pattern and checks
  always @(posedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 200;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no progress");
      $display("testbench: errors");
      $finish;
    end
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_answers.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = expected_answers.pop_front();
        if (e.t != 32'sd65536) hits_seen++;
        if (e.ov) overlaps_seen++;
        if (got.t !== e.t) report("hit_time", got.t, e.t);
        if (got.rx !== e.rx) report("resolved_x", got.rx, e.rx);
        if (got.ry !== e.ry) report("resolved_y", got.ry, e.ry);
        if (got.nx !== e.nx) report("normal_x", got.nx, e.nx);
        if (got.ny !== e.ny) report("normal_y", got.ny, e.ny);
        if (got.ov !== e.ov) report("overlapping", got.ov, e.ov);
      end
    end
  end

  task automatic offer(query_t q, bit typed, answer_t a);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    drv <= q;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    expected_answers.push_back(typed ? a : collide(q));
  endtask

  function automatic logic signed [31:0] near(int span);
    return $signed(32'($urandom_range(2 * span))) - span;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      q.bx = $urandom; q.by = $urandom; q.tx = $urandom; q.ty = $urandom;
      q.ox = $urandom; q.oy = $urandom;
      q.bhx = 31'($urandom); q.bhy = 31'($urandom);
      q.ohx = 31'($urandom); q.ohy = 31'($urandom);
    end else begin
      q.bx = near(20 << 16); q.by = near(20 << 16);
      q.bhx = 31'($urandom_range(4 << 16)); q.bhy = 31'($urandom_range(4 << 16));
      q.ohx = 31'($urandom_range(6 << 16)); q.ohy = 31'($urandom_range(6 << 16));
      q.ox = q.bx + near(10 << 16); q.oy = q.by + near(10 << 16);
      q.tx = q.ox + near(12 << 16); q.ty = q.oy + near(12 << 16);
      if (kind == 1) begin
        q.ox = q.bx + near(2 << 16); q.oy = q.by + near(2 << 16);
        q.tx = q.bx; q.ty = q.by;
      end else if (kind == 2) begin
        q.ox = q.bx + near(2 << 16); q.oy = q.by + near(2 << 16);
      end else if (kind == 3) begin
        q.ty = q.by;
      end else if (kind == 4) begin
        q.tx = q.bx + $urandom_range(3) - 1;
      end
    end
    return q;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    answer_t none;
    none = '{default: '0};
    // all zero: zero-size boxes touching, no motion, a miss
    rw.q = '{default: '0}; rw.typed = 1;
    rw.a = '{t: 32'sd65536, rx: 0, ry: 0, nx: swbc_pkg::NRM_ZERO, ny: swbc_pkg::NRM_ZERO,
             ov: 0};
    rows.push_back(rw);
    // resting overlap, pushed out along x
    rw.q = '{bx: 0, by: 0, bhx: 31'h10000, bhy: 31'h10000, tx: 0, ty: 0,
             ox: 32'sh8000, oy: 0, ohx: 31'h10000, ohy: 31'h10000};
    rw.a = '{t: 0, rx: 0, ry: 0, nx: swbc_pkg::NRM_NEG, ny: swbc_pkg::NRM_ZERO, ov: 1};
    rows.push_back(rw);
    // far miss moving away
    rw.q = '{bx: 0, by: 0, bhx: 31'h10000, bhy: 31'h10000, tx: -32'sh50000,
             ty: 32'sh30000, ox: 32'sh500000, oy: 0, ohx: 31'h10000, ohy: 31'h10000};
    rw.a = '{t: 32'sd65536, rx: -32'sh50000, ry: 32'sh30000, nx: swbc_pkg::NRM_ZERO,
             ny: swbc_pkg::NRM_ZERO, ov: 0};
    rows.push_back(rw);
    rw.typed = 0; rw.a = none;
    // head-on hits from each side
    rw.q = '{bx: 0, by: 0, bhx: 31'h10000, bhy: 31'h10000, tx: 32'sh80000, ty: 0,
             ox: 32'sh40000, oy: 0, ohx: 31'h10000, ohy: 31'h10000};
    rows.push_back(rw);
    rw.q.tx = -32'sh80000; rw.q.ox = -32'sh40000; rows.push_back(rw);
    rw.q = '{bx: 0, by: 0, bhx: 31'h8000, bhy: 31'h8000, tx: 32'sh8000, ty: 32'sh90000,
             ox: 0, oy: 32'sh40000, ohx: 31'h20000, ohy: 31'h10000};
    rows.push_back(rw);
    rw.q.ty = -32'sh90000; rw.q.oy = -32'sh40000; rows.push_back(rw);
    // diagonal, corner graze, parallel slide
    rw.q = '{bx: 0, by: 0, bhx: 31'h10000, bhy: 31'h10000, tx: 32'sh60000,
             ty: 32'sh60000, ox: 32'sh40000, oy: 32'sh40000, ohx: 31'h10000,
             ohy: 31'h10000};
    rows.push_back(rw);
    rw.q.oy = 32'sh60000; rows.push_back(rw);
    rw.q.ty = 0; rw.q.oy = 32'sh20000; rows.push_back(rw);
    // overlap with motion
    rw.q = '{bx: 0, by: 0, bhx: 31'h10000, bhy: 31'h10000, tx: 32'sh30000, ty: 32'sh1000,
             ox: 32'sh8000, oy: 0, ohx: 31'h10000, ohy: 31'h10000};
    rows.push_back(rw);
    rw.q.tx = 1; rw.q.ty = 0; rows.push_back(rw);
    rw.q.tx = 0; rw.q.ty = -1; rows.push_back(rw);
    // extremes of every field
    rw.q = '{bx: 32'sh80000000, by: 32'sh7fffffff, bhx: '1, bhy: '1, tx: 32'sh7fffffff,
             ty: 32'sh80000000, ox: 32'sh7fffffff, oy: 32'sh80000000, ohx: '1, ohy: '1};
    rows.push_back(rw);
    rw.q.tx = rw.q.bx; rw.q.ty = rw.q.by; rows.push_back(rw);
    rw.q = '{bx: 32'sh7fffffff, by: 32'sh80000000, bhx: 0, bhy: 0, tx: 32'sh80000000,
             ty: 32'sh7fffffff, ox: 32'sh80000000, oy: 32'sh7fffffff, ohx: 0, ohy: 0};
    rows.push_back(rw);
    rw.q = '{bx: 0, by: 0, bhx: '1, bhy: '1, tx: 32'sh7fffffff, ty: 1,
             ox: 0, oy: 0, ohx: '1, ohy: '1};
    rows.push_back(rw);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29; recv_idle_pct = 56;
    foreach (rows[i]) offer(rows[i].q, rows[i].typed, rows[i].a);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 56; recv_idle_pct = 29;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
        // sender waits for the pipe to drain, then the receiver holds off
        in_valid <= 1'b0;
        wait (expected_answers.size() == 0);
        @(posedge clk_i);
        hold_request = 1'b1;
      end
      repeat (360) offer(random_query(), 0, none);
    end
    in_valid <= 1'b0;
    wait (expected_answers.size() == 0);
    repeat (80) @(posedge clk_i);
    $display("covered %0d results: %0d hits or overlaps, %0d overlapping starts",
             results_seen, hits_seen, overlaps_seen);
    $display("directed rows, three idling patterns and a long output hold-off");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
